### src/wea_pkg.sv
// Shared constants, types and arithmetic helpers for the windowed angle average.
package wea_pkg;

   localparam int WINDOW      = 16;
   localparam int ANGLE_BITS  = 16;
   localparam int AXES        = 3;
   localparam int IN_BITS     = 16;
   localparam int OUT_BITS    = 16;
   localparam int ALPHA_BITS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int PTR_BITS    = $clog2(WINDOW);
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int TRIPLE_BITS = AXES * ANGLE_BITS;
   localparam int EXT_BITS    = (ANGLE_BITS > IN_BITS) ? ANGLE_BITS : IN_BITS;
   localparam int SAT_BITS    = (ANGLE_BITS + 1 > OUT_BITS + 1) ? ANGLE_BITS + 1 : OUT_BITS + 1;
   localparam int PROD_BITS   = ANGLE_BITS + ALPHA_BITS + 2;
   localparam int SUM_BITS    = PROD_BITS + 1;

   localparam longint ANGLE_MAX  = (longint'(1) <<< (ANGLE_BITS - 1)) - 1;
   localparam longint ANGLE_MIN  = -ANGLE_MAX - 1;
   localparam longint OUT_MAX    = (longint'(1) <<< (OUT_BITS - 1)) - 1;
   localparam longint OUT_MIN    = -OUT_MAX - 1;
   localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);

   localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd58982;

   localparam logic MODE_SAMPLE  = 1'b0;
   localparam logic MODE_CAPTURE = 1'b1;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef angle_type [AXES-1:0] triple_type;

   typedef struct packed {
      logic       capture;
      triple_type angles;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   function automatic angle_type clamp_angle(input logic signed [IN_BITS-1:0] v);
      logic signed [EXT_BITS-1:0] w;
      w = EXT_BITS'(v);
      if (w > EXT_BITS'(ANGLE_MAX)) begin
         return ANGLE_BITS'(EXT_BITS'(ANGLE_MAX));
      end
      if (w < EXT_BITS'(ANGLE_MIN)) begin
         return ANGLE_BITS'(EXT_BITS'(ANGLE_MIN));
      end
      return ANGLE_BITS'(w);
   endfunction

   // alpha*avg + (1-alpha)*x == alpha*(avg - x) + x, scaled by 2^FRAC_BITS
   function automatic logic signed [PROD_BITS-1:0] ewma_product(
      input logic [ALPHA_BITS-1:0] alpha,
      input angle_type             avg,
      input angle_type             x
   );
      logic signed [ANGLE_BITS:0] d;
      logic signed [ALPHA_BITS:0] a;
      d = (ANGLE_BITS + 1)'(avg) - (ANGLE_BITS + 1)'(x);
      a = $signed({1'b0, alpha});
      return PROD_BITS'(a) * PROD_BITS'(d);
   endfunction

   function automatic angle_type ewma_round(
      input logic signed [PROD_BITS-1:0] p,
      input angle_type                   x
   );
      logic signed [SUM_BITS-1:0] s;
      s = SUM_BITS'(p) + (SUM_BITS'(x) <<< FRAC_BITS) + SUM_BITS'(ROUND_HALF);
      return ANGLE_BITS'(s >>> FRAC_BITS);
   endfunction

   function automatic logic [OUT_BITS-1:0] sat_diff(input angle_type a, input angle_type b);
      logic signed [SAT_BITS-1:0] d;
      d = SAT_BITS'(a) - SAT_BITS'(b);
      if (d > SAT_BITS'(OUT_MAX)) begin
         return OUT_BITS'(SAT_BITS'(OUT_MAX));
      end
      if (d < SAT_BITS'(OUT_MIN)) begin
         return OUT_BITS'(SAT_BITS'(OUT_MIN));
      end
      return OUT_BITS'(d);
   endfunction

endpackage

### src/wea_ram.sv
// Generic simple dual-port RAM with registered read.
module wea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wea_front.sv
// Front end: accepts items, decodes the mode, clamps samples and queues commands.
module wea_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,  // roll_in, pitch_in, yaw_in
   input  logic             req_tuser,  // mode
   output logic             cmd_valid,
   output wea_pkg::cmd_type cmd,
   input  logic             cmd_pop
);

   wea_pkg::cmd_type                 q_ff [wea_pkg::QUEUE_DEPTH];
   wea_pkg::cmd_type                 q_in [wea_pkg::QUEUE_DEPTH];
   logic [wea_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [wea_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [wea_pkg::QCNT_BITS-1:0]    cnt_ff, cnt_in;
   wea_pkg::cmd_type                 entry;
   logic                             push;

   assign req_tready = cnt_ff != wea_pkg::QCNT_BITS'(wea_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = cnt_ff != '0;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      entry.capture = req_tuser == wea_pkg::MODE_CAPTURE;
      for (int j = 0; j < wea_pkg::AXES; j++) begin
         entry.angles[j] = wea_pkg::clamp_angle(req_tdata[wea_pkg::IN_BITS*j +: wea_pkg::IN_BITS]);
      end
   end

   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         q_in[wr_ptr_ff] = entry;
         wr_ptr_in = (wr_ptr_ff == wea_pkg::QPTR_BITS'(wea_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + wea_pkg::QPTR_BITS'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == wea_pkg::QPTR_BITS'(wea_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + wea_pkg::QPTR_BITS'(1);
      end
      cnt_in = cnt_ff + wea_pkg::QCNT_BITS'(push) - wea_pkg::QCNT_BITS'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

### src/wea_back.sv
// Back end: window store, serial average walk, offsets and result register.
module wea_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [wea_pkg::ALPHA_BITS-1:0] alpha,
   input  logic                           cmd_valid,
   input  wea_pkg::cmd_type               cmd,
   output logic                           cmd_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [95:0]                    rsp_tdata
);

   wea_pkg::state_type              state_ff, state_in;
   logic [wea_pkg::PTR_BITS-1:0]    wp_ff, wp_in;
   logic [wea_pkg::PTR_BITS-1:0]    idx_ff, idx_in;
   logic [wea_pkg::PTR_BITS-1:0]    cnt_ff, cnt_in;
   logic [wea_pkg::WINDOW-1:0]      valid_ff, valid_in;
   logic                            rd_valid_ff, rd_valid_in;
   wea_pkg::triple_type             latest_ff, latest_in;
   wea_pkg::triple_type             avg_ff, avg_in;
   wea_pkg::triple_type             aoff_ff, aoff_in;
   wea_pkg::triple_type             avgoff_ff, avgoff_in;
   wea_pkg::triple_type             x_ff, x_in;
   logic signed [wea_pkg::PROD_BITS-1:0] prod_ff [wea_pkg::AXES];
   logic signed [wea_pkg::PROD_BITS-1:0] prod_in [wea_pkg::AXES];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [95:0]                     rsp_data_ff, rsp_data_in;

   logic                            wr_en;
   logic                            rd_en;
   logic [wea_pkg::PTR_BITS-1:0]    rd_addr;
   logic [wea_pkg::TRIPLE_BITS-1:0] rd_data;
   wea_pkg::triple_type             x_now;
   logic [wea_pkg::PTR_BITS-1:0]    wp_next;
   logic [wea_pkg::PTR_BITS-1:0]    idx_next;

   wea_ram #(
      .WIDTH(wea_pkg::TRIPLE_BITS),
      .DEPTH(wea_pkg::WINDOW)
   ) u_window (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wp_ff),
      .wr_data(cmd.angles),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // never-written slots read as zero
   assign x_now    = rd_valid_ff ? wea_pkg::triple_type'(rd_data) : '0;
   assign wp_next  = (wp_ff == wea_pkg::PTR_BITS'(wea_pkg::WINDOW - 1)) ?
                     '0 : wp_ff + wea_pkg::PTR_BITS'(1);
   assign idx_next = (idx_ff == wea_pkg::PTR_BITS'(wea_pkg::WINDOW - 1)) ?
                     '0 : idx_ff + wea_pkg::PTR_BITS'(1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      rd_valid_in  = rd_valid_ff;
      latest_in    = latest_ff;
      avg_in       = avg_ff;
      aoff_in      = aoff_ff;
      avgoff_in    = avgoff_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = idx_next;

      case (state_ff)
         wea_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.capture) begin
                  aoff_in   = latest_ff;
                  avgoff_in = avg_ff;
                  state_in  = wea_pkg::ST_DONE;
               end else begin
                  wr_en           = 1'b1;
                  valid_in[wp_ff] = 1'b1;
                  latest_in       = cmd.angles;
                  wp_in           = wp_next;
                  rd_en           = 1'b1;
                  rd_addr         = wp_next;
                  idx_in          = wp_next;
                  rd_valid_in     = valid_ff[wp_next];
                  cnt_in          = '0;
                  state_in        = wea_pkg::ST_FIRST;
               end
            end
         end
         wea_pkg::ST_FIRST: begin
            avg_in      = x_now;
            rd_en       = 1'b1;
            idx_in      = idx_next;
            rd_valid_in = valid_ff[idx_next];
            cnt_in      = cnt_ff + wea_pkg::PTR_BITS'(1);
            state_in    = wea_pkg::ST_MUL;
         end
         wea_pkg::ST_MUL: begin
            for (int j = 0; j < wea_pkg::AXES; j++) begin
               prod_in[j] = wea_pkg::ewma_product(alpha, avg_ff[j], x_now[j]);
            end
            x_in     = x_now;
            state_in = wea_pkg::ST_ACC;
         end
         wea_pkg::ST_ACC: begin
            for (int j = 0; j < wea_pkg::AXES; j++) begin
               avg_in[j] = wea_pkg::ewma_round(prod_ff[j], x_ff[j]);
            end
            if (cnt_ff == wea_pkg::PTR_BITS'(wea_pkg::WINDOW - 1)) begin
               state_in = wea_pkg::ST_DONE;
            end else begin
               rd_en       = 1'b1;
               idx_in      = idx_next;
               rd_valid_in = valid_ff[idx_next];
               cnt_in      = cnt_ff + wea_pkg::PTR_BITS'(1);
               state_in    = wea_pkg::ST_MUL;
            end
         end
         wea_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               for (int j = 0; j < wea_pkg::AXES; j++) begin
                  rsp_data_in[wea_pkg::OUT_BITS*j +: wea_pkg::OUT_BITS] =
                     wea_pkg::sat_diff(latest_ff[j], aoff_ff[j]);
                  rsp_data_in[wea_pkg::OUT_BITS*(wea_pkg::AXES + j) +: wea_pkg::OUT_BITS] =
                     wea_pkg::sat_diff(avg_ff[j], avgoff_ff[j]);
               end
               state_in = wea_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wea_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wea_pkg::ST_IDLE;
         wp_ff        <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         latest_ff    <= '0;
         avg_ff       <= '0;
         aoff_ff      <= '0;
         avgoff_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rd_valid_ff  <= rd_valid_in;
         latest_ff    <= latest_in;
         avg_ff       <= avg_in;
         aoff_ff      <= aoff_in;
         avgoff_ff    <= avgoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/windowed_exponential_angle_average.sv
// Top level: windowed exponential average of roll, pitch and yaw with zero offsets.
// Sample: the back end walks the window, oldest entry first, with one RAM read and one
// multiply/round step per entry; it takes no new command until the walk is done and its
// result register is free. A two-entry command queue lets req_ take items meanwhile.
// Synchronous reset clears the window valid bits, pointer, angles, averages and offsets,
// and sets alpha_q16 to 58982; no clearing pass, items are taken right after reset.
module windowed_exponential_angle_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // roll_in, pitch_in, yaw_in
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // roll_rel, pitch_rel, yaw_rel,
                                    // roll_avg_rel, pitch_avg_rel, yaw_avg_rel
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // alpha_q16
);

   logic [wea_pkg::ALPHA_BITS-1:0] alpha_ff, alpha_in;
   logic                           cmd_valid;
   logic                           cmd_pop;
   wea_pkg::cmd_type               cmd;

   assign alpha_in = csr_wr_en ? csr_wr_data : alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= wea_pkg::ALPHA_RESET;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   wea_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   wea_back u_back (
      .clock     (clock),
      .reset     (reset),
      .alpha     (alpha_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> !cmd_pop)
      else $error("back end popped two commands in a row");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
